// ===== hdl/hashed_integer_set_assert.svh =====
`ifndef HASHED_INTEGER_SET_ASSERT_SVH
`define HASHED_INTEGER_SET_ASSERT_SVH

// Both macros expect clk and arst_n in the scope where they are used.

`define HSET_ASSERT_NOW(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`define HSET_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== hdl/hset_pkg.sv =====
package hset_pkg;

	localparam int VALUE_W = 32;
	localparam int TOTAL_W = 12;
	localparam int CFG_W = 4;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic [CFG_W-1:0] BITS_RESET = 4'd8;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = 12'd4095;

	typedef struct packed {
		logic req_type;
		logic [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic found;
		logic bucket_full;
		logic [TOTAL_W-1:0] member_total;
	} res_t;

endpackage

// ===== hdl/hset_fifo.sv =====
module hset_fifo #(
	parameter int W = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [W-1:0] din,
	output logic full,
	input  logic pop,
	output logic [W-1:0] dout,
	output logic empty
);
	logic [W-1:0] entry_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign dout = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			if (do_push && !do_pop) count_q <= count_q + 2'd1;
			else if (do_pop && !do_push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= din;
	end
endmodule

// ===== hdl/hset_front.sv =====
module hset_front #(
	parameter int BUCKETS_LOG2 = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic bucket_bits_we,
	input  logic [hset_pkg::CFG_W-1:0] bucket_bits,
	input  logic push,
	input  logic req_type,
	input  logic [hset_pkg::VALUE_W-1:0] value,
	input  logic blocked,
	output logic full,
	output logic q_push,
	output logic [$bits(hset_pkg::req_t)+BUCKETS_LOG2-1:0] q_data
);
	import hset_pkg::*;

	localparam logic [CFG_W:0] BL_MAX = (CFG_W + 1)'(BUCKETS_LOG2);

	logic [CFG_W-1:0] bits_q;
	logic [CFG_W-1:0] eff_bits;
	logic [BUCKETS_LOG2-1:0] mask;
	logic [BUCKETS_LOG2-1:0] bucket;
	req_t req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= BITS_RESET;
		end else if (bucket_bits_we) begin
			bits_q <= bucket_bits;
		end
	end

	// The register value is clamped into the range of buckets that exist.
	always_comb begin
		if (bits_q == '0) eff_bits = CFG_W'(1);
		else if ({1'b0, bits_q} > BL_MAX) eff_bits = BL_MAX[CFG_W-1:0];
		else eff_bits = bits_q;
		mask = BUCKETS_LOG2'((32'd1 << eff_bits) - 32'd1);
		bucket = value[BUCKETS_LOG2-1:0] & mask;
		req.req_type = req_type;
		req.value = value;
	end

	assign full = blocked;
	assign q_push = push && !blocked;
	assign q_data = {req, bucket};
endmodule

// ===== hdl/hset_back.sv =====
module hset_back #(
	parameter int BUCKETS_LOG2 = 8,
	parameter int SLOTS_PER_BUCKET = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  logic [$bits(hset_pkg::req_t)+BUCKETS_LOG2-1:0] q_data,
	output logic q_pop,
	input  logic r_full,
	output logic r_push,
	output hset_pkg::res_t r_data,
	output logic clearing
);
	import hset_pkg::*;
	`include "hashed_integer_set_assert.svh"

	localparam int NB = 1 << BUCKETS_LOG2;
	localparam int S = SLOTS_PER_BUCKET;
	localparam int FW = $clog2(S + 1);
	localparam int SW = S * VALUE_W;
	localparam int ROW_W = FW + SW;
	localparam logic [FW-1:0] FILL_MAX = FW'(S);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_CALC = 2'd2;

	logic [ROW_W-1:0] mem_q [NB];
	logic [ROW_W-1:0] rd_row_q;
	logic [1:0] state_q;
	logic [BUCKETS_LOG2-1:0] clr_idx_q;
	logic [BUCKETS_LOG2-1:0] bucket_q;
	logic [VALUE_W-1:0] value_q;
	logic type_q;
	logic [TOTAL_W-1:0] total_q;
	logic [TOTAL_W-1:0] total_next;

	req_t q_req;
	logic [BUCKETS_LOG2-1:0] q_bucket;
	logic [FW-1:0] fill;
	logic [SW-1:0] slots;
	logic [SW-1:0] shifted;
	logic [SW-1:0] new_slots;
	logic [FW-1:0] new_fill;
	logic [S-1:0] lt;
	logic [S-1:0] lt_prev;
	logic [S-1:0] eq;
	logic found;
	logic drop;
	logic do_ins;
	logic mem_we;
	logic [BUCKETS_LOG2-1:0] mem_waddr;
	logic [ROW_W-1:0] mem_wdata;

	assign {q_req, q_bucket} = q_data;
	assign clearing = (state_q == ST_CLEAR);
	assign q_pop = (state_q == ST_IDLE) && !q_empty && !r_full;

	// Members are kept sorted, so the slots below the value form a prefix.
	always_comb begin
		fill = rd_row_q[ROW_W-1 -: FW];
		slots = rd_row_q[SW-1:0];
		shifted = slots << VALUE_W;
		for (int i = 0; i < S; i++) begin
			lt[i] = (FW'(i) < fill) &&
				($signed(slots[i*VALUE_W +: VALUE_W]) < $signed(value_q));
			eq[i] = (FW'(i) < fill) && (slots[i*VALUE_W +: VALUE_W] == value_q);
		end
		lt_prev = S'({lt, 1'b1});
		for (int i = 0; i < S; i++) begin
			if (lt[i]) new_slots[i*VALUE_W +: VALUE_W] = slots[i*VALUE_W +: VALUE_W];
			else if (lt_prev[i]) new_slots[i*VALUE_W +: VALUE_W] = value_q;
			else new_slots[i*VALUE_W +: VALUE_W] = shifted[i*VALUE_W +: VALUE_W];
		end
		found = |eq;
		drop = (type_q == REQ_INSERT) && !found && (fill == FILL_MAX);
		do_ins = (type_q == REQ_INSERT) && !found && (fill != FILL_MAX);
		new_fill = fill + FW'(1);
		total_next = (do_ins && total_q != TOTAL_MAX) ? total_q + TOTAL_W'(1) : total_q;
	end

	always_comb begin
		mem_we = clearing || ((state_q == ST_CALC) && do_ins);
		mem_waddr = clearing ? clr_idx_q : bucket_q;
		mem_wdata = clearing ? '0 : {new_fill, new_slots};
	end

	assign r_push = (state_q == ST_CALC);
	assign r_data.found = found;
	assign r_data.bucket_full = drop;
	assign r_data.member_total = total_next;

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_waddr] <= mem_wdata;
		if (q_pop) rd_row_q <= mem_q[q_bucket];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			bucket_q <= q_bucket;
			value_q <= q_req.value;
			type_q <= q_req.req_type;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_idx_q <= '0;
			total_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + BUCKETS_LOG2'(1);
					if (&clr_idx_q) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (q_pop) state_q <= ST_CALC;
				end
				ST_CALC: begin
					total_q <= total_next;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	`HSET_ASSERT_NEXT(a_pop_then_calc, q_pop, state_q == ST_CALC, "pop did not lead to update")
	`HSET_ASSERT_NOW(a_fill_bound, !(mem_we && !clearing) || new_fill <= FILL_MAX, "fill overrun")
	`HSET_ASSERT_NOW(a_no_result_in_clear, !(clearing && (r_push || q_pop)), "busy during clear")
	`HSET_ASSERT_NEXT(a_total_monotone, state_q != ST_CLEAR, total_q >= $past(total_q), "count fell")
endmodule

// ===== hdl/hashed_integer_set.sv =====
// A request is registered in the request queue, its bucket row is read into a register, and its
// result is registered in the result queue before it shows on the result ports. A bucket row
// is read, then written back sorted on an insert; the back end takes no new request until then.
// After reset a clearing pass zeroes every bucket fill count; full stays high until it ends.
// Configuration writes are taken throughout.
module hashed_integer_set #(
	parameter int BUCKETS_LOG2 = 8,
	parameter int SLOTS_PER_BUCKET = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic bucket_bits_we,
	input  logic [hset_pkg::CFG_W-1:0] bucket_bits,
	input  logic push,
	output logic full,
	input  logic req_type,
	input  logic signed [hset_pkg::VALUE_W-1:0] value,
	input  logic pop,
	output logic empty,
	output logic found,
	output logic bucket_full,
	output logic [hset_pkg::TOTAL_W-1:0] member_total
);
	import hset_pkg::*;

	localparam int QW = $bits(req_t) + BUCKETS_LOG2;

	logic q_push;
	logic [QW-1:0] q_in;
	logic q_full;
	logic q_pop;
	logic [QW-1:0] q_out;
	logic q_empty;
	logic clearing;
	logic r_push;
	logic r_full;
	res_t r_in;
	res_t r_out;

	hset_front #(.BUCKETS_LOG2(BUCKETS_LOG2)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.bucket_bits_we(bucket_bits_we),
		.bucket_bits(bucket_bits),
		.push(push),
		.req_type(req_type),
		.value(value),
		.blocked(q_full || clearing),
		.full(full),
		.q_push(q_push),
		.q_data(q_in)
	);

	hset_fifo #(.W(QW)) u_req_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.din(q_in),
		.full(q_full),
		.pop(q_pop),
		.dout(q_out),
		.empty(q_empty)
	);

	hset_back #(
		.BUCKETS_LOG2(BUCKETS_LOG2),
		.SLOTS_PER_BUCKET(SLOTS_PER_BUCKET)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_data(q_out),
		.q_pop(q_pop),
		.r_full(r_full),
		.r_push(r_push),
		.r_data(r_in),
		.clearing(clearing)
	);

	hset_fifo #(.W($bits(res_t))) u_res_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(r_push),
		.din(r_in),
		.full(r_full),
		.pop(pop),
		.dout(r_out),
		.empty(empty)
	);

	assign found = r_out.found;
	assign bucket_full = r_out.bucket_full;
	assign member_total = r_out.member_total;
endmodule
